### hw/rtl/sorted_matrix_staircase_search_assert.svh
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH

// same-cycle implication
`define SMSS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/smss_pkg.sv
// ----------------------------------------------------------------------------
// smss_pkg
// sizes, types and helpers shared by the staircase search block
// ----------------------------------------------------------------------------
`default_nettype none

package smss_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int FIELD_W   = 32;
    localparam int POS_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // width wide enough for both a register value and the size limits
    localparam int RLIM_W = $clog2(MAX_ROWS + 1);
    localparam int CLIM_W = $clog2(MAX_COLS + 1);
    localparam int LIM_W  = (RLIM_W > CLIM_W) ? RLIM_W : CLIM_W;
    localparam int SIZE_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    // transaction kinds on the func field
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_CORNER,
        S_CHECK,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } dims_t;

    typedef struct packed
    {
        logic gt;
        logic lt;
        logic eq;
    } cmp_t;

    typedef struct packed
    {
        logic             found;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } hit_t;

    typedef struct packed
    {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        value_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // sign-extend or wrap a 32-bit field to the stored value width
    function automatic value_t to_value(input logic [FIELD_W-1:0] field);
        return VALUE_WIDTH'($signed(field));
    endfunction

endpackage

`default_nettype wire

### hw/rtl/smss_ram.sv
// ----------------------------------------------------------------------------
// smss_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/smss_cmp.sv
// ----------------------------------------------------------------------------
// smss_cmp
// shared signed three-way compare of the key against one matrix entry
// ----------------------------------------------------------------------------
`default_nettype none

module smss_cmp
    import smss_pkg::*;
(
    input  wire value_t key,
    input  wire value_t entry,
    output cmp_t        result
);

    always_comb
    begin
        result.gt = key > entry;
        result.lt = key < entry;
        result.eq = key == entry;
    end

endmodule

`default_nettype wire

### hw/rtl/smss_seq.sv
// ----------------------------------------------------------------------------
// smss_seq
// sequencer: takes items, writes entries, walks the staircase for a search
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_matrix_staircase_search_assert.svh"

module smss_seq
    import smss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               func,
    input  wire logic [POS_W-1:0]   entry_row,
    input  wire logic [POS_W-1:0]   entry_col,
    input  wire logic [FIELD_W-1:0] entry_value,
    input  wire logic [FIELD_W-1:0] search_key,
    input  wire dims_t              dims,
    input  wire logic               out_free,
    input  wire value_t             rd_data,
    output logic                    busy,
    output ram_req_t                ram_req,
    output logic                    res_done,
    output hit_t                    res_hit
);

    state_t           state_reg, state_next;
    value_t           key_reg, key_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    hit_t             hit_reg, hit_next;

    logic [SIZE_W-1:0] rows_ext, cols_ext, rows_sat, cols_sat;
    logic [ROW_W-1:0]  last_row;
    logic [COL_W-1:0]  last_col;
    logic              size_zero;
    logic              accept;
    logic              wr_in_range;
    cmp_t              cmp;

    // matrix in use, saturated to the storage size
    always_comb
    begin
        rows_ext  = SIZE_W'(dims.rows);
        cols_ext  = SIZE_W'(dims.cols);
        rows_sat  = (rows_ext > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_ext;
        cols_sat  = (cols_ext > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_ext;
        last_row  = ROW_W'(rows_sat - SIZE_W'(1));
        last_col  = COL_W'(cols_sat - SIZE_W'(1));
        size_zero = (dims.rows == '0) || (dims.cols == '0);
    end

    smss_cmp u_cmp
    (
        .key    (key_reg),
        .entry  (rd_data),
        .result (cmp)
    );

    assign accept      = req_valid && (state_reg == S_IDLE);
    assign busy        = state_reg != S_IDLE;
    assign wr_in_range = (int'(entry_row) < MAX_ROWS) && (int'(entry_col) < MAX_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        row_reg <= row_next;
        col_reg <= col_next;
        hit_reg <= hit_next;
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        hit_next   = hit_reg;
        res_done   = 1'b0;

        ram_req.we    = accept && (func == FUNC_WRITE) && wr_in_range;
        ram_req.waddr = {ROW_W'(entry_row), COL_W'(entry_col)};
        ram_req.wdata = to_value(entry_value);
        ram_req.raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // top-left entry is read while the key is registered
                if (accept && (func == FUNC_SEARCH))
                begin
                    key_next   = to_value(search_key);
                    hit_next   = '0;
                    state_next = size_zero ? S_DONE : S_CORNER;
                end
            end
            S_CORNER:
            begin
                ram_req.raddr = {last_row, last_col};
                state_next    = cmp.gt ? S_DONE : S_CHECK;
            end
            S_CHECK:
            begin
                ram_req.raddr = {last_row, COL_W'(0)};
                row_next      = last_row;
                col_next      = '0;
                state_next    = cmp.lt ? S_DONE : S_WALK;
            end
            S_WALK:
            begin
                if (cmp.eq)
                begin
                    hit_next   = '{found: 1'b1, row: row_reg, col: col_reg};
                    state_next = S_DONE;
                end
                else if (cmp.gt)
                begin
                    if (row_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        row_next = row_reg - ROW_W'(1);
                    end
                end
                else
                begin
                    if (col_reg == last_col)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                // next entry is fetched in the same cycle as the decision
                ram_req.raddr = {row_next, col_next};
            end
            S_DONE:
            begin
                res_done = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_hit = hit_reg;

    `SMSS_ASSERT_IMPL(a_walk_in_bounds, state_reg == S_WALK,
        (row_reg <= last_row) && (col_reg <= last_col), "walk left the matrix in use")
    `SMSS_ASSERT_NEXT(a_match_reported, (state_reg == S_WALK) && cmp.eq,
        (state_reg == S_DONE) && hit_reg.found, "match not reported")
    `SMSS_ASSERT_NEXT(a_write_single_cycle, accept && (func == FUNC_WRITE),
        state_reg == S_IDLE, "write transaction did not complete in one cycle")

endmodule

`default_nettype wire

### hw/rtl/sorted_matrix_staircase_search.sv
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search
// staircase search over a row and column sorted matrix held in ram
// ----------------------------------------------------------------------------
// A write transaction (func 0) stores one entry and gives no result. A search
// transaction (func 1) first compares the key with the top-left and then the
// bottom-right entry, and unless these corner checks reject it, walks the
// staircase from the bottom-left corner, visiting at most rows + cols - 1
// entries. A matrix with no rows or no columns skips the corner checks and the
// walk. The single ram read port sets the pace of a search: one entry is
// fetched and compared per cycle.
// req_stall is high while a search is in progress or its result waits to enter
// the output register. One result waits in the output register, so the next
// item is taken while it is still unread.
`default_nettype none

`include "sorted_matrix_staircase_search_assert.svh"

module sorted_matrix_staircase_search
    import smss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic                 func,
    input  wire logic [POS_W-1:0]     entry_row,
    input  wire logic [POS_W-1:0]     entry_col,
    input  wire logic [FIELD_W-1:0]   entry_value,
    input  wire logic [FIELD_W-1:0]   search_key,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic                      found,
    output logic [POS_W-1:0]          hit_row,
    output logic [POS_W-1:0]          hit_col,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic             rsp_valid_reg, rsp_valid_next;
    hit_t             out_reg;

    dims_t    dims;
    ram_req_t ram_req;
    value_t   rd_data;
    logic     busy;
    logic     res_done;
    hit_t     res_hit;
    logic     out_free;
    logic     out_load;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS: rows_next = cfg_data;
                CFG_COLS: cols_next = cfg_data;
                default:  ;
            endcase
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign out_load = res_done && out_free;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= ROWS_RESET;
            cols_reg      <= COLS_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_hit;
        end
    end

    assign dims = '{rows: rows_reg, cols: cols_reg};

    smss_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rd_data)
    );

    smss_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .func        (func),
        .entry_row   (entry_row),
        .entry_col   (entry_col),
        .entry_value (entry_value),
        .search_key  (search_key),
        .dims        (dims),
        .out_free    (out_free),
        .rd_data     (rd_data),
        .busy        (busy),
        .ram_req     (ram_req),
        .res_done    (res_done),
        .res_hit     (res_hit)
    );

    assign req_stall = busy;
    assign rsp_valid = rsp_valid_reg;
    assign found     = out_reg.found;
    assign hit_row   = POS_W'(out_reg.row);
    assign hit_col   = POS_W'(out_reg.col);

    `SMSS_ASSERT_NEXT(a_result_held, res_done && !out_free,
        res_done && $stable(res_hit), "finished result dropped while output full")

endmodule

`default_nettype wire

### verif/smss_search_checker.sv
// ----------------------------------------------------------------------------
// smss_search_checker
// watches the request, response and register channels of the staircase search
// block, keeps its own copy of the matrix and the size registers, predicts each
// search outcome and compares it with the response stream in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module smss_search_checker
    import smss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 req_stall,
    input  wire logic                 func,
    input  wire logic [POS_W-1:0]     entry_row,
    input  wire logic [POS_W-1:0]     entry_col,
    input  wire logic [FIELD_W-1:0]   entry_value,
    input  wire logic [FIELD_W-1:0]   search_key,
    input  wire logic                 rsp_valid,
    input  wire logic                 rsp_stall,
    input  wire logic                 found,
    input  wire logic [POS_W-1:0]     hit_row,
    input  wire logic [POS_W-1:0]     hit_col,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        error_count,
    output int                        pending_results,
    output int                        hits_seen
);

    localparam int REPORT_LIMIT = 10;

    value_t           grid [MAX_ROWS][MAX_COLS];
    logic [CFG_W-1:0] rows_cfg;
    logic [CFG_W-1:0] cols_cfg;
    hit_t             expected_hits [$];
    int               results_seen;

    // walk from the bottom-left corner: larger key goes up, smaller goes right
    function automatic hit_t predict_search(input value_t key);
        hit_t   res;
        int     nr;
        int     nc;
        int     r;
        int     c;
        value_t e;
        res = '0;
        nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        nc = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
        if (nr == 0 || nc == 0)
        begin
            return res;
        end
        if (key > grid[0][0] || key < grid[nr-1][nc-1])
        begin
            return res;
        end
        r = nr - 1;
        c = 0;
        while (r >= 0 && c < nc)
        begin
            e = grid[r][c];
            if (key > e)
            begin
                r--;
            end
            else if (key < e)
            begin
                c++;
            end
            else
            begin
                res.found = 1'b1;
                res.row   = r[ROW_W-1:0];
                res.col   = c[COL_W-1:0];
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_t want;
        if (!rst_n)
        begin
            rows_cfg     = ROWS_RESET;
            cols_cfg     = COLS_RESET;
            error_count  = 0;
            hits_seen    = 0;
            results_seen = 0;
            expected_hits.delete();
        end
        else
        begin
            // responses first: a search taken at this edge cannot answer yet
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_hits.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected response %0d: found=%0b row=%0d col=%0d",
                                 results_seen, found, hit_row, hit_col);
                    end
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (want.found)
                    begin
                        hits_seen++;
                    end
                    if (found !== want.found || hit_row !== want.row ||
                        hit_col !== want.col)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("search %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                                     results_seen, want.found, want.row, want.col,
                                     found, hit_row, hit_col);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROWS)
                begin
                    rows_cfg = cfg_data;
                end
                else if (cfg_index == CFG_COLS)
                begin
                    cols_cfg = cfg_data;
                end
            end
            if (req_valid && !req_stall)
            begin
                if (func == FUNC_SEARCH)
                begin
                    expected_hits.push_back(predict_search($signed(search_key)));
                end
                else
                begin
                    grid[entry_row][entry_col] = $signed(entry_value);
                end
            end
        end
        pending_results = expected_hits.size();
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives the staircase search block with directed corner cases and then
// phases of sorted matrices of many shapes followed by mixed searches and
// stray writes, under varying request gaps and response back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import smss_pkg::*;
();

    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 6;
    localparam int     TARGET_ITEMS = 1950;
    localparam int     LONG_HOLD    = 400;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     END_CYCLES   = 140;
    localparam longint CYCLE_LIMIT  = 3000000;
    localparam longint VALUE_MAX    = 64'sd2147483647;
    localparam longint VALUE_MIN    = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 req_valid   = 1'b0;
    logic                 req_stall;
    logic                 func        = FUNC_WRITE;
    logic [POS_W-1:0]     entry_row   = '0;
    logic [POS_W-1:0]     entry_col   = '0;
    logic [FIELD_W-1:0]   entry_value = '0;
    logic [FIELD_W-1:0]   search_key  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall   = 1'b0;
    logic                 found;
    logic [POS_W-1:0]     hit_row;
    logic [POS_W-1:0]     hit_col;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;

    int error_count;
    int pending_results;
    int hits_seen;

    idle_mode_t idle_mode     = IDLE_NONE;
    int         hold_requests = 0;
    int         writes_sent   = 0;
    int         searches_sent = 0;
    int         phases_run    = 0;
    int         random_items  = 0;
    int         fill_rows     = 0;
    int         fill_cols     = 0;
    longint     cycle_count   = 0;

    logic [FIELD_W-1:0] shadow [MAX_ROWS][MAX_COLS];
    longint             layout [MAX_ROWS][MAX_COLS];

    sorted_matrix_staircase_search dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .entry_row   (entry_row),
        .entry_col   (entry_col),
        .entry_value (entry_value),
        .search_key  (search_key),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .found       (found),
        .hit_row     (hit_row),
        .hit_col     (hit_col),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    smss_search_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .func            (func),
        .entry_row       (entry_row),
        .entry_col       (entry_col),
        .entry_value     (entry_value),
        .search_key      (search_key),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .found           (found),
        .hit_row         (hit_row),
        .hit_col         (hit_col),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results),
        .hits_seen       (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[sorted_matrix_staircase_search] ERROR");
        $finish;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 61;
            IDLE_BOTH:   return $urandom_range(0, 99) < 23;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 61;
            IDLE_BOTH:     return $urandom_range(0, 99) < 23;
            default:       return 1'b0;
        endcase
    endfunction

    // response side: random stalls, or a long hold-off when one is requested
    initial
    begin
        int served = 0;
        forever
        begin
            @(negedge clk);
            if (served != hold_requests)
            begin
                served++;
                rsp_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                rsp_stall = receiver_stalls();
            end
        end
    end

    // one request transaction, entered and left at a falling edge
    task automatic send_item(input logic op, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] c, input logic [FIELD_W-1:0] v,
                             input logic [FIELD_W-1:0] k);
        while (sender_idles())
        begin
            @(negedge clk);
        end
        req_valid   = 1'b1;
        func        = op;
        entry_row   = r;
        entry_col   = c;
        entry_value = v;
        search_key  = k;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        req_valid = 1'b0;
        if (op == FUNC_WRITE)
        begin
            writes_sent++;
            shadow[r][c] = v;
        end
        else
        begin
            searches_sent++;
        end
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait out outstanding searches, then let a trailing write drain
    task automatic settle();
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        settle();
        write_config(CFG_ROWS, rows);
        write_config(CFG_COLS, cols);
        fill_rows = (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
        fill_cols = (cols > MAX_COLS) ? MAX_COLS : int'(cols);
    endtask

    // non-increasing along rows and columns, then shifted into 32-bit range
    task automatic fill_sorted();
        int     step;
        int     r;
        int     c;
        longint v;
        longint lo;
        longint off;
        if (fill_rows == 0 || fill_cols == 0)
        begin
            return;
        end
        case ($urandom_range(0, 3))
            0:       step = 0;
            1:       step = 2;
            2:       step = 50;
            default: step = 1 << 20;
        endcase
        for (r = 0; r < fill_rows; r++)
        begin
            for (c = 0; c < fill_cols; c++)
            begin
                if (r == 0 && c == 0)
                begin
                    v = 0;
                end
                else if (r == 0)
                begin
                    v = layout[0][c-1];
                end
                else if (c == 0)
                begin
                    v = layout[r-1][0];
                end
                else
                begin
                    v = (layout[r-1][c] < layout[r][c-1]) ?
                        layout[r-1][c] : layout[r][c-1];
                end
                layout[r][c] = v - $urandom_range(0, step);
            end
        end
        lo = VALUE_MIN - layout[fill_rows-1][fill_cols-1];
        case ($urandom_range(0, 3))
            0:       off = VALUE_MAX;
            1:       off = lo;
            default: off = lo + longint'($urandom % (VALUE_MAX - lo + 1));
        endcase
        for (r = 0; r < fill_rows; r++)
        begin
            for (c = 0; c < fill_cols; c++)
            begin
                v = layout[r][c] + off;
                send_item(FUNC_WRITE, r[POS_W-1:0], c[POS_W-1:0], v[FIELD_W-1:0], $urandom);
            end
        end
    endtask

    function automatic logic [FIELD_W-1:0] pick_key();
        int                 r;
        int                 c;
        logic [FIELD_W-1:0] e;
        if (fill_rows == 0 || fill_cols == 0)
        begin
            return $urandom;
        end
        r = $urandom_range(0, fill_rows - 1);
        c = $urandom_range(0, fill_cols - 1);
        e = shadow[r][c];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return e;
            4:          return e + 1;
            5:          return e - 1;
            6:          return shadow[0][0] + 1;
            7:          return shadow[fill_rows-1][fill_cols-1] - 1;
            8:          return $urandom;
            default:    return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    // mostly searches; stray writes land anywhere in the store
    task automatic run_traffic(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(FUNC_WRITE, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
            end
            else
            begin
                send_item(FUNC_SEARCH, POS_W'($urandom), POS_W'($urandom), $urandom,
                          pick_key());
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        int               n;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: spare register indexes, a 2 x 2 matrix at the value extremes
        write_config(CFG_SPARE_A, CFG_W'($urandom));
        write_config(CFG_SPARE_B, CFG_W'($urandom));
        set_size(7'd2, 7'd2);
        send_item(FUNC_WRITE, 6'd0, 6'd0, 32'h7fff_ffff, $urandom);
        send_item(FUNC_WRITE, 6'd0, 6'd1, 32'd5, $urandom);
        send_item(FUNC_WRITE, 6'd1, 6'd0, 32'd5, $urandom);
        send_item(FUNC_WRITE, 6'd1, 6'd1, 32'h8000_0000, $urandom);
        send_item(FUNC_SEARCH, 6'd63, 6'd63, $urandom, 32'h7fff_ffff);
        send_item(FUNC_SEARCH, 6'd0, 6'd0, $urandom, 32'h8000_0000);
        send_item(FUNC_SEARCH, POS_W'($urandom), POS_W'($urandom), $urandom, 32'd5);
        send_item(FUNC_SEARCH, POS_W'($urandom), POS_W'($urandom), $urandom, 32'd6);
        send_item(FUNC_SEARCH, POS_W'($urandom), POS_W'($urandom), $urandom, 32'hffff_fff9);
        // empty matrix in either dimension never finds anything
        set_size(7'd0, 7'd3);
        send_item(FUNC_SEARCH, POS_W'($urandom), POS_W'($urandom), $urandom, 32'd0);
        set_size(7'd1, 7'd0);
        send_item(FUNC_SEARCH, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);

        while (random_items < TARGET_ITEMS)
        begin
            case (phases_run)
                0:
                begin
                    rows = 7'd64;
                    cols = 7'd1;
                end
                1:
                begin
                    rows = 7'd1;
                    cols = 7'd64;
                end
                2:
                begin
                    rows = 7'd127;
                    cols = CFG_W'($urandom_range(1, 2));
                end
                3:
                begin
                    rows = CFG_W'($urandom_range(1, 2));
                    cols = CFG_W'($urandom_range(65, 127));
                end
                4:
                begin
                    rows = 7'd0;
                    cols = 7'd127;
                end
                default:
                begin
                    case ($urandom_range(0, 19))
                        0:
                        begin
                            rows = 7'd64;
                            cols = CFG_W'($urandom_range(1, 2));
                        end
                        1:
                        begin
                            rows = CFG_W'($urandom_range(1, 2));
                            cols = 7'd64;
                        end
                        2:
                        begin
                            rows = CFG_W'($urandom_range(65, 127));
                            cols = 7'd1;
                        end
                        3:
                        begin
                            rows = CFG_W'($urandom_range(0, 127));
                            cols = 7'd0;
                        end
                        4:
                        begin
                            rows = 7'd1;
                            cols = 7'd1;
                        end
                        5, 6:
                        begin
                            rows = CFG_W'($urandom_range(1, 16));
                            cols = CFG_W'($urandom_range(1, 16));
                        end
                        default:
                        begin
                            rows = CFG_W'($urandom_range(1, 8));
                            cols = CFG_W'($urandom_range(1, 8));
                        end
                    endcase
                end
            endcase
            set_size(rows, cols);
            idle_mode = idle_mode_t'(phases_run % 4);
            fill_sorted();
            random_items += fill_rows * fill_cols;
            // response side holds off while requests keep coming
            if (phases_run == 6)
            begin
                hold_requests++;
            end
            n = (fill_rows == 0 || fill_cols == 0) ? 8 : $urandom_range(30, 70);
            run_traffic(n);
            random_items += n;
            phases_run++;
        end

        settle();
        repeat (END_CYCLES) @(negedge clk);

        $display("covered %0d matrix shapes after the directed checks:", phases_run);
        $display("%0d writes, %0d searches, %0d hits, from empty and 1 x 1 to 64-long",
                 writes_sent, searches_sent, hits_seen);
        if (error_count == 0 && pending_results == 0)
        begin
            $display("[sorted_matrix_staircase_search] OK");
        end
        else
        begin
            $display("[sorted_matrix_staircase_search] ERROR");
        end
        $finish;
    end

endmodule
